// ----- rtl/core/rsm_pkg.sv -----
`default_nettype none

package rsm_pkg;

    // job store depth
    localparam int MAX_JOBS = 32;

    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int TIME_W = 16;
    localparam int SPAN_W = 23;
    localparam int NUM_W  = 7;

    // one stored job
    typedef struct packed {
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] proc;
        logic [TIME_W-1:0] deliv;
        logic [CNT_W-1:0]  num;
    } job_t;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic start;
        logic step;
        logic rewind;
        logic emit;
    } rsm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic busy;
        logic out_free;
    } rsm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/rsm_ctrl.sv -----
`default_nettype none

module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  logic      last_job,
    output logic      job_stall,
    input  rsm_stat_t stat,
    output rsm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCHED,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        job_stall  = (state_reg != S_LOAD);
        case (state_reg)
            S_LOAD:
            begin
                cmd.store = job_valid;
                if (job_valid && last_job)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCHED;
                end
            end
            S_SCHED:
            begin
                cmd.step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the end-time and makespan stages to settle
                if (!stat.busy)
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rsm_datapath.sv -----
`default_nettype none

module rsm_datapath
    import rsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsm_cmd_t          cmd,
    output rsm_stat_t         stat,
    input  logic [TIME_W-1:0] release_time,
    input  logic [TIME_W-1:0] processing_time,
    input  logic [TIME_W-1:0] delivery_time,
    input  logic              result_stall,
    output logic              result_valid,
    output logic [NUM_W-1:0]  job_number,
    output logic              last_result,
    output logic [SPAN_W-1:0] makespan,
    output logic [SPAN_W-1:0] final_end_time,
    output logic              overflow
);

    // sorted job row, entries below count_reg are live
    job_t              row_reg [MAX_JOBS];
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [IDX_W-1:0]  idx_reg;

    // schedule pipeline
    job_t              rd_reg;
    logic              rd_v_reg;
    logic [SPAN_W-1:0] t_reg;
    logic [TIME_W-1:0] q_d_reg;
    logic              s2_v_reg;
    logic [SPAN_W-1:0] cmax_reg;

    // output word
    logic              result_valid_reg;
    logic [NUM_W-1:0]  job_number_reg;
    logic              last_result_reg;
    logic [SPAN_W-1:0] makespan_reg;
    logic [SPAN_W-1:0] final_end_time_reg;
    logic              overflow_reg;

    logic [MAX_JOBS-1:0] move;
    logic [MAX_JOBS-1:0] wr;
    job_t              ins_val [MAX_JOBS];
    job_t              new_job;
    logic [CNT_W-1:0]  new_num;
    logic              full;
    logic              idx_last;
    logic              out_free;
    job_t              rd_sel;
    logic [SPAN_W-1:0] t_max;
    logic [SPAN_W-1:0] t_next;
    logic [SPAN_W-1:0] tq;

    assign full     = (count_reg == CNT_W'(MAX_JOBS));
    assign new_num  = count_reg + CNT_W'(1);
    assign new_job  = '{rel: release_time, proc: processing_time,
                        deliv: delivery_time, num: new_num};
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free = !result_valid_reg || !result_stall;
    assign rd_sel   = row_reg[idx_reg];

    assign stat.idx_last = idx_last;
    assign stat.busy     = rd_v_reg || s2_v_reg;
    assign stat.out_free = out_free;

    // insert cells: later release shifts up one place, ties stay ahead
    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            move[i]    = (CNT_W'(i) < count_reg) && (row_reg[i].rel > release_time);
            wr[i]      = move[i] || (CNT_W'(i) == count_reg);
            ins_val[i] = new_job;
            if (i > 0)
            begin
                if (move[i-1])
                begin
                    ins_val[i] = row_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            if (cmd.store && !full && wr[i])
            begin
                row_reg[i] <= ins_val[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.store)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= new_num;
            end
        end
        else if (cmd.emit && idx_last)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.start || cmd.rewind)
        begin
            idx_reg <= '0;
        end
        else if (cmd.step || cmd.emit)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // stage 1: end time, stage 2: end plus delivery into the running max
    assign t_max  = (SPAN_W'(rd_reg.rel) > t_reg) ? SPAN_W'(rd_reg.rel) : t_reg;
    assign t_next = t_max + SPAN_W'(rd_reg.proc);
    assign tq     = t_reg + SPAN_W'(q_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.step;
            s2_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rd_reg <= rd_sel;
        end
        if (cmd.start)
        begin
            t_reg    <= '0;
            cmax_reg <= '0;
        end
        else
        begin
            if (rd_v_reg)
            begin
                t_reg   <= t_next;
                q_d_reg <= rd_reg.deliv;
            end
            if (s2_v_reg && (tq > cmax_reg))
            begin
                cmax_reg <= tq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            job_number_reg     <= NUM_W'(rd_sel.num);
            last_result_reg    <= idx_last;
            makespan_reg       <= idx_last ? cmax_reg : '0;
            final_end_time_reg <= idx_last ? t_reg : '0;
            overflow_reg       <= ovf_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign job_number     = job_number_reg;
    assign last_result    = last_result_reg;
    assign makespan       = makespan_reg;
    assign final_end_time = final_end_time_reg;
    assign overflow       = overflow_reg;

endmodule

`default_nettype wire

// ----- rtl/core/release_sort_makespan.sv -----
// load: jobs load one per cycle while job_stall is low; after the word marked last_job the
//   controller runs the schedule pass, drains the end-time and makespan stages, then walks out
//   the result words; the pass and the walk share the single read port of the job row, and
//   no new set is loaded until the last result word of the set is emitted
// reset: rst_n is asynchronous, active low; clears job count, overflow flag,
//   controller state and output valid; stored jobs are undefined until written
`default_nettype none

module release_sort_makespan
    import rsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // job words
    input  logic              job_valid,
    output logic              job_stall,
    input  logic [TIME_W-1:0] release_time,
    input  logic [TIME_W-1:0] processing_time,
    input  logic [TIME_W-1:0] delivery_time,
    input  logic              last_job,
    // result words
    output logic              result_valid,
    input  logic              result_stall,
    output logic [NUM_W-1:0]  job_number,
    output logic              last_result,
    output logic [SPAN_W-1:0] makespan,
    output logic [SPAN_W-1:0] final_end_time,
    output logic              overflow
);

    // the controller sequences load, schedule pass, drain and output walk;
    // the datapath keeps the job row sorted by release time on every insert,
    // so the sort costs nothing extra after the last job arrives
    rsm_cmd_t  cmd;
    rsm_stat_t stat;

    rsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .last_job  (last_job),
        .job_stall (job_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // job row, two-stage end-time and makespan pipeline, output register
    rsm_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .release_time    (release_time),
        .processing_time (processing_time),
        .delivery_time   (delivery_time),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .job_number      (job_number),
        .last_result     (last_result),
        .makespan        (makespan),
        .final_end_time  (final_end_time),
        .overflow        (overflow)
    );

endmodule

`default_nettype wire

// ----- rtl/core/release_sort_makespan_checker.sv -----
`default_nettype none

module release_sort_makespan_checker
    import rsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  logic              job_stall,
    input  logic              last_job,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [NUM_W-1:0]  job_number,
    input  logic              last_result,
    input  logic [SPAN_W-1:0] makespan,
    input  logic [SPAN_W-1:0] final_end_time,
    input  logic              overflow
);

    // a stalled word holds (final_end_time is not checked here)
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(job_number)
            && $stable(last_result) && $stable(makespan) && $stable(overflow))
        else $error("stalled result word changed");

    // totals only ride on the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> makespan == '0 && final_end_time == '0)
        else $error("totals on a word other than the last");

    // makespan covers the final end time
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> makespan >= final_end_time)
        else $error("makespan below final end time");

    // job numbers lie in 1..MAX_JOBS
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> job_number != '0 && job_number <= NUM_W'(MAX_JOBS))
        else $error("job number out of range");

    // last job accepted: job_stall is then raised (only its start is checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall && last_job |=> job_stall)
        else $error("job taken during schedule pass");

endmodule

bind release_sort_makespan release_sort_makespan_checker u_chk (.*);

`default_nettype wire

// ----- tb/release_sort_makespan_test.sv -----
`default_nettype none

module release_sort_makespan_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    // run size and the watchdog bound on cycles with no word moving
    localparam int ITEMS       = 430;
    localparam int STILL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    // how the times of a random set are drawn
    typedef enum int {FILL_WIDE, FILL_TIES, FILL_TOP} fill_t;

    // one job word on its way into the block
    typedef struct {
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] proc;
        logic [TIME_W-1:0] deliv;
        logic              fin;
    } job_word_t;

    // one job as the predictor holds it
    typedef struct {
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] proc;
        logic [TIME_W-1:0] deliv;
        logic [NUM_W-1:0]  tag;
    } held_job_t;

    // one result word the block owes us
    typedef struct {
        logic [NUM_W-1:0]  job_number;
        logic              last_result;
        logic [SPAN_W-1:0] makespan;
        logic [SPAN_W-1:0] final_end_time;
        logic              overflow;
    } order_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              job_valid = 1'b0;
    logic              job_stall;
    logic [TIME_W-1:0] release_time = '0;
    logic [TIME_W-1:0] processing_time = '0;
    logic [TIME_W-1:0] delivery_time = '0;
    logic              last_job = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [NUM_W-1:0]  job_number;
    logic              last_result;
    logic [SPAN_W-1:0] makespan;
    logic [SPAN_W-1:0] final_end_time;
    logic              overflow;

    // job words still to send, and sorted result words still due
    job_word_t   pending_jobs[$];
    order_word_t due_words[$];

    // predictor copy of the block's job store
    held_job_t   shop[MAX_JOBS];
    int          shop_count = 0;
    logic        shop_overflow = 1'b0;

    job_word_t   staged;
    order_word_t due_word;
    int          fails = 0;
    int          jobs_taken = 0;
    int unsigned send_gap = 0;
    int unsigned quiet_sends = 0;
    int unsigned take_wait = 0;
    int unsigned quiet_takes = 0;
    int unsigned hold_cnt = 0;
    int          holds_done = 0;
    int unsigned still_cycles = 0;
    logic        hold_off;

    release_sort_makespan dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_stall       (job_stall),
        .release_time    (release_time),
        .processing_time (processing_time),
        .delivery_time   (delivery_time),
        .last_job        (last_job),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .job_number      (job_number),
        .last_result     (last_result),
        .makespan        (makespan),
        .final_end_time  (final_end_time),
        .overflow        (overflow)
    );

    always #5 clk = ~clk;

    // idle length: mostly none, often short, now and then long
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // store one accepted job; on the final job of a set, sort stably by
    // release time, run the machine in that order and queue the result words
    task automatic take_job(input logic [TIME_W-1:0] rel, input logic [TIME_W-1:0] proc,
                            input logic [TIME_W-1:0] deliv, input logic fin);
        held_job_t         ranked[MAX_JOBS];
        held_job_t         key;
        logic [SPAN_W-1:0] now;
        logic [SPAN_W-1:0] span;
        order_word_t       word;
        int                k;
        if (shop_count < MAX_JOBS)
        begin
            shop[shop_count] = '{rel, proc, deliv, NUM_W'(shop_count + 1)};
            shop_count++;
        end
        else
            shop_overflow = 1'b1;   // store full: job dropped, even a final one
        if (fin)
        begin
            for (int i = 0; i < shop_count; i++)
                ranked[i] = shop[i];
            // insertion sort, strict compare keeps ties in arrival order
            for (int i = 1; i < shop_count; i++)
            begin
                key = ranked[i];
                k = i;
                while (k > 0 && ranked[k-1].rel > key.rel)
                begin
                    ranked[k] = ranked[k-1];
                    k--;
                end
                ranked[k] = key;
            end
            // machine waits for the release when it is idle before it
            now = '0;
            span = '0;
            for (int i = 0; i < shop_count; i++)
            begin
                if (SPAN_W'(ranked[i].rel) > now)
                    now = SPAN_W'(ranked[i].rel);
                now = now + SPAN_W'(ranked[i].proc);
                if (now + SPAN_W'(ranked[i].deliv) > span)
                    span = now + SPAN_W'(ranked[i].deliv);
            end
            for (int i = 0; i < shop_count; i++)
            begin
                word.job_number     = ranked[i].tag;
                word.last_result    = (i == shop_count - 1);
                word.makespan       = word.last_result ? span : '0;
                word.final_end_time = word.last_result ? now : '0;
                word.overflow       = shop_overflow;
                due_words = {due_words, word};
            end
            shop_count = 0;
            shop_overflow = 1'b0;
        end
    endtask

    task automatic push_job(input logic [TIME_W-1:0] rel, input logic [TIME_W-1:0] proc,
                            input logic [TIME_W-1:0] deliv, input logic fin);
        job_word_t w;
        w = '{rel, proc, deliv, fin};
        pending_jobs = {pending_jobs, w};
    endtask

    // a set of n jobs with random times, last_job on the final one
    task automatic push_set(input int n, input fill_t fill);
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] proc;
        logic [TIME_W-1:0] deliv;
        int unsigned       roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            case (fill)
                FILL_TOP:
                begin
                    rel = '1;
                    proc = '1;
                    deliv = '1;
                end
                FILL_TIES:
                begin
                    rel = TIME_W'($urandom_range(0, 3));
                    proc = TIME_W'($urandom_range(0, 15));
                    deliv = TIME_W'($urandom_range(0, 65535));
                end
                default:
                begin
                    if (roll < 50)
                        rel = TIME_W'($urandom_range(0, 65535));
                    else if (roll < 75)
                        rel = TIME_W'($urandom_range(0, 2000));
                    else
                        rel = TIME_W'($urandom_range(0, 31));
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        proc = TIME_W'($urandom_range(0, 2000));
                    else if (roll < 90)
                        proc = TIME_W'($urandom_range(0, 65535));
                    else
                        proc = '0;
                    deliv = TIME_W'($urandom_range(0, 65535));
                end
            endcase
            push_job(rel, proc, deliv, i == n - 1);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int    set_no;
        int    n;
        fill_t fill;

        // single job at the top of every field, then at zero
        push_job('1, '1, '1, 1'b1);
        push_job('0, '0, '0, 1'b1);
        // reversed releases with a tie in the middle; job four, released at zero,
        // keeps the machine busy past every later release
        push_job(16'd300, 16'd5, 16'd0, 1'b0);
        push_job(16'd200, 16'd0, 16'hFFFF, 1'b0);
        push_job(16'd200, 16'd7, 16'd3, 1'b0);
        push_job(16'd0, 16'hFFFF, 16'd1, 1'b1);
        // all releases equal: arrival order must survive
        push_job(16'd0, 16'd1, 16'd2, 1'b0);
        push_job(16'd0, 16'd3, 16'd1, 1'b0);
        push_job(16'd0, 16'd2, 16'd9, 1'b1);
        // long tail on the earlier job decides the makespan
        push_job(16'd1000, 16'd10, 16'd5, 1'b0);
        push_job(16'd10, 16'd10, 16'd50000, 1'b1);

        // random sets, with a full store, a dropped final job and a set
        // that overflows on plain jobs placed among them
        set_no = 0;
        while (pending_jobs.size() < ITEMS)
        begin
            fill = ($urandom_range(0, 99) < 80) ? FILL_WIDE : FILL_TIES;
            if (set_no == 3)
            begin
                n = MAX_JOBS;
                fill = FILL_TOP;
            end
            else if (set_no == 8)
                n = MAX_JOBS + 1;
            else if (set_no == 14)
                n = MAX_JOBS + 4;
            else if (set_no == 20)
                n = MAX_JOBS;
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 65)
                    n = $urandom_range(1, 8);
                else if (n < 90)
                    n = $urandom_range(9, 24);
                else
                    n = $urandom_range(25, MAX_JOBS);
            end
            push_set(n, fill);
            set_no++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge, away from the clocked blocks
        while (pending_jobs.size() != 0 || job_valid)
            @(negedge clk);
        while (due_words.size() != 0)
            @(negedge clk);
        // anything arriving now is an extra word
        repeat (2 * MAX_JOBS + 8) @(negedge clk);

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // job driver: a stalled word holds, an accepted word goes to the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid <= 1'b0;
            send_gap <= 0;
            quiet_sends <= 0;
        end
        else if (!(job_valid && job_stall))
        begin
            if (job_valid)
            begin
                take_job(release_time, processing_time, delivery_time, last_job);
                jobs_taken <= jobs_taken + 1;
            end
            if (send_gap != 0 || pending_jobs.size() == 0)
            begin
                job_valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                staged = pending_jobs.pop_front();
                job_valid <= 1'b1;
                release_time <= staged.rel;
                processing_time <= staged.proc;
                delivery_time <= staged.deliv;
                last_job <= staged.fin;
                // occasional run of back-to-back words
                if (quiet_sends != 0)
                begin
                    quiet_sends <= quiet_sends - 1;
                    send_gap <= 0;
                end
                else
                begin
                    send_gap <= idle_len();
                    if ($urandom_range(0, 99) < 3)
                        quiet_sends <= 40;
                end
            end
        end
    end

    // long receiver hold-off, twice, while jobs keep coming, so the block
    // waits in its output walk and has to stall the job side
    assign hold_off = (hold_cnt != 0);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            holds_done <= 0;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (holds_done < 2 && jobs_taken >= 150 * (holds_done + 1))
        begin
            hold_cnt <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // result monitor and random stall on the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            take_wait <= 0;
            quiet_takes <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with nothing due: job_number %0d", job_number);
                    fails++;
                end
                else
                begin
                    due_word = due_words.pop_front();
                    if (job_number !== due_word.job_number)
                    begin
                        $error("job_number: expected %0d, got %0d",
                               due_word.job_number, job_number);
                        fails++;
                    end
                    if (last_result !== due_word.last_result)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               due_word.last_result, last_result);
                        fails++;
                    end
                    if (makespan !== due_word.makespan)
                    begin
                        $error("makespan: expected %0d, got %0d",
                               due_word.makespan, makespan);
                        fails++;
                    end
                    if (final_end_time !== due_word.final_end_time)
                    begin
                        $error("final_end_time: expected %0d, got %0d",
                               due_word.final_end_time, final_end_time);
                        fails++;
                    end
                    if (overflow !== due_word.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               due_word.overflow, overflow);
                        fails++;
                    end
                end
            end
            if (take_wait != 0)
            begin
                take_wait <= take_wait - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= hold_off;
                if (quiet_takes != 0)
                    quiet_takes <= quiet_takes - 1;
                else
                begin
                    take_wait <= idle_len();
                    if ($urandom_range(0, 99) < 2)
                        quiet_takes <= 60;
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            still_cycles <= 0;
        else if ((job_valid && !job_stall) || (result_valid && !result_stall))
            still_cycles <= 0;
        else if (still_cycles == STILL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STILL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            still_cycles <= still_cycles + 1;
    end

endmodule

`default_nettype wire
